// File: src/htd_pkg.sv
// Shared types, constants and tables for the haversine track distance block.
`default_nettype none
package htd_pkg;

  // Width of the CORDIC x/y datapath and of its angle accumulator.
  localparam int unsigned CW = 34;
  localparam int unsigned ZW = 33;

  localparam logic signed [31:0] UNIT_RAD_Q60   = 32'sd2012227627;
  localparam logic signed [31:0] DIST_SCALE     = 32'sd127420000;
  localparam logic signed [CW-1:0] CORDIC_START_X = 34'sh026DD3B6A;
  localparam logic signed [ZW-1:0] HALF_PI_Q30  = 33'sd1686629713;
  localparam logic signed [33:0] HALF_TURN_S    = 34'sd1800000000;
  localparam logic signed [33:0] FULL_TURN_S    = 34'sd3600000000;
  localparam logic [30:0] HALF_TURN_U           = 31'd1800000000;
  localparam logic [30:0] QUARTER_TURN_U        = 31'd900000000;
  localparam logic signed [63:0] ONE_Q60        = 64'sh1000_0000_0000_0000;
  localparam logic signed [63:0] HALF_Q30       = 64'sd536870912;
  localparam logic signed [63:0] ONE_Q30_64     = 64'sd1073741824;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_ANG_MUL, S_ANG, S_ROT, S_MUL_CC, S_RND_P, S_MUL_PS,
    S_RND_W, S_MUL_WS, S_SUM, S_SQ1, S_SQ2I, S_SQ2, S_VGO, S_VEC, S_MUL_D,
    S_RND_D, S_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctrl_t;

  function automatic logic [29:0] atan_q30(input logic [5:0] idx);
    logic [29:0] r;
    case (idx)
      6'd0:  r = 30'h3243F6A8;
      6'd1:  r = 30'h1DAC6705;
      6'd2:  r = 30'h0FADBAFD;
      6'd3:  r = 30'h07F56EA6;
      6'd4:  r = 30'h03FEAB76;
      6'd5:  r = 30'h01FFD55B;
      6'd6:  r = 30'h00FFFAAA;
      6'd7:  r = 30'h007FFF55;
      6'd8:  r = 30'h003FFFEA;
      6'd9:  r = 30'h001FFFFD;
      6'd10: r = 30'h000FFFFF;
      6'd11: r = 30'h0007FFFF;
      6'd12: r = 30'h0003FFFF;
      6'd13: r = 30'h0001FFFF;
      6'd14: r = 30'h0000FFFF;
      6'd15: r = 30'h00007FFF;
      6'd16: r = 30'h00003FFF;
      6'd17: r = 30'h00001FFF;
      6'd18: r = 30'h00000FFF;
      6'd19: r = 30'h000007FF;
      6'd20: r = 30'h000003FF;
      6'd21: r = 30'h000001FF;
      6'd22: r = 30'h000000FF;
      6'd23: r = 30'h0000007F;
      6'd24: r = 30'h0000003F;
      6'd25: r = 30'h0000001F;
      6'd26: r = 30'h0000000F;
      6'd27: r = 30'h00000008;
      6'd28: r = 30'h00000004;
      6'd29: r = 30'h00000002;
      6'd30: r = 30'h00000001;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

  // Clamp a CORDIC output to [-1, 1] in Q30.
  function automatic logic signed [31:0] clamp_unit(input logic signed [CW-1:0] v);
    logic signed [31:0] r;
    if (v > 34'sd1073741824) begin
      r = 32'sd1073741824;
    end else if (v < -34'sd1073741824) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Round a Q60 product half up to Q30.
  function automatic logic signed [31:0] round_q30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + HALF_Q30;
    return t[61:30];
  endfunction

endpackage
`default_nettype wire

// File: src/htd_if.sv
// Valid/ready channel interfaces for fixes in and distance results out.
`default_nettype none
interface htd_in_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] latitude;
  logic signed [31:0] longitude;
  modport source (output valid, output latitude, output longitude, input ready);
  modport sink (input valid, input latitude, input longitude, output ready);
endinterface

interface htd_out_if;
  logic        valid;
  logic        ready;
  logic        first_fix;
  logic [27:0] segment_distance;
  logic [47:0] total_distance;
  logic [31:0] fix_count;
  modport source (output valid, output first_fix, output segment_distance,
                  output total_distance, output fix_count, input ready);
  modport sink (input valid, input first_fix, input segment_distance,
                input total_distance, input fix_count, output ready);
endinterface
`default_nettype wire

// File: src/htd_cordic.sv
// Iterative CORDIC unit, one micro-rotation per cycle, rotation or vectoring mode.
`default_nettype none
module htd_cordic import htd_pkg::*; #(
  parameter int unsigned ITERATIONS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cordic_ctrl_t        ctrl_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic                done_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);
  localparam int unsigned CNT_W = $clog2(ITERATIONS);

  logic               busy_q, done_q, vec_q;
  logic [CNT_W-1:0]   cnt_q;
  logic signed [CW-1:0] x_q, y_q, dx, dy;
  logic signed [ZW-1:0] z_q, at;
  logic               cw;

  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign at = ZW'(atan_q30(6'(cnt_q)));
  // Rotate toward the target: by the residual angle, or toward the x axis.
  assign cw = vec_q ? (y_q >= 0) : (z_q < 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(ITERATIONS - 1));
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(ITERATIONS - 1)) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      x_q   <= x_i;
      y_q   <= y_i;
      z_q   <= z_i;
      vec_q <= ctrl_i.vectoring;
    end else if (busy_q) begin
      if (cw) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
endmodule
`default_nettype wire

// File: src/haversine_track_distance_unit.sv
// Top level: haversine distance between successive GPS fixes with running totals.
// Each fix is taken when in_i is ready, which is only while the block is idle. The first
// fix after reset goes straight to the commit state. Every later fix takes four sin/cos
// evaluations and one arctangent on the single shared CORDIC unit, plus two 32-step square
// roots on a shared compare-and-subtract stage. When the haversine term comes out zero, as
// for a repeated position, the square roots and the arctangent are skipped. One 32x32
// multiplier is shared by all products. A finished result waits in the output register
// while the next fix is already being worked on. The totals are committed when that
// register is free, so a result that still waits there holds the next fix back in its
// last state.
`default_nettype none
module haversine_track_distance_unit import htd_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  htd_in_if.sink    in_i,
  htd_out_if.source out_o
);
  state_e state_q, state_d;

  logic [1:0]         job_q;
  logic signed [30:0] new_lat_q, last_lat_q;
  logic signed [31:0] new_lon_q, last_lon_q;
  logic               have_prev_q, first_q;
  logic [47:0]        total_q;
  logic [31:0]        count_q;
  logic               out_valid_q, out_first_q;
  logic [27:0]        out_seg_q, seg_q;

  logic [30:0]        m_q, m_d;
  logic               neg_q, neg_d;
  logic signed [63:0] mul_q;
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] s1_q, s2_q, c1_q, c2_q, t_q;
  logic signed [63:0] acc_q, a_sum, rnd;
  logic [60:0]        a_q, a_clamp;
  logic [63:0]        n_q, res_q, bit_q, trial;
  logic [4:0]         sq_cnt_q;
  logic [30:0]        sqx_q, theta_q;
  logic signed [32:0] theta_c;

  logic signed [33:0] dif, red, red_abs;
  logic signed [30:0] lat_sel;
  logic signed [31:0] lat_w, lat_abs;
  logic signed [ZW-1:0] ang;
  logic signed [31:0] sin_c, cos_c;
  logic               accept, commit;
  logic [48:0]        total_sum;

  cordic_ctrl_t         cctrl;
  logic signed [CW-1:0] c_x0, c_y0, c_x, c_y;
  logic signed [ZW-1:0] c_z0, c_z;
  logic                 c_done;

  htd_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cctrl),
    .x_i    (c_x0),
    .y_i    (c_y0),
    .z_i    (c_z0),
    .done_o (c_done),
    .x_o    (c_x),
    .y_o    (c_y),
    .z_o    (c_z)
  );

  // Angle operand for the current job: half differences first, then latitudes.
  always_comb begin
    dif = job_q[0] ? (34'(new_lon_q) - 34'(last_lon_q))
                   : (34'(new_lat_q) - 34'(last_lat_q));
    if (dif >= HALF_TURN_S) begin
      red = dif - FULL_TURN_S;
    end else if (dif < -HALF_TURN_S) begin
      red = dif + FULL_TURN_S;
    end else begin
      red = dif;
    end
    red_abs = (red < 0) ? -red : red;
    lat_sel = job_q[0] ? new_lat_q : last_lat_q;
    lat_w   = 32'(lat_sel);
    lat_abs = (lat_w < 0) ? -lat_w : lat_w;
    neg_d   = 1'b0;
    if (!job_q[1]) begin
      m_d = red_abs[30:0];
    end else if (lat_abs[30:0] > QUARTER_TURN_U) begin
      // Beyond the pole the cosine is the negated cosine of the supplement.
      m_d   = HALF_TURN_U - lat_abs[30:0];
      neg_d = 1'b1;
    end else begin
      m_d = lat_abs[30:0];
    end
  end

  always_comb begin
    rnd   = mul_q + ((job_q[1] || (state_q == S_RND_D)) ? HALF_Q30 : ONE_Q30_64);
    ang   = job_q[1] ? rnd[62:30] : rnd[63:31];
    sin_c = clamp_unit(c_y);
    cos_c = clamp_unit(c_x);
    a_sum = acc_q + mul_q;
    if (a_sum < 0) begin
      a_clamp = '0;
    end else if (a_sum > ONE_Q60) begin
      a_clamp = ONE_Q60[60:0];
    end else begin
      a_clamp = a_sum[60:0];
    end
    trial = res_q + bit_q;
    if (c_z < 0) begin
      theta_c = '0;
    end else if (c_z > HALF_PI_Q30) begin
      theta_c = HALF_PI_Q30;
    end else begin
      theta_c = c_z;
    end
    total_sum = {1'b0, total_q} + 49'(seg_q);
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = {1'b0, m_q};
    mul_b = UNIT_RAD_Q60;
    case (state_q)
      S_MUL_CC: begin mul_a = c1_q; mul_b = c2_q; end
      S_MUL_PS: begin mul_a = t_q;  mul_b = s2_q; end
      S_RND_W:  begin mul_a = s1_q; mul_b = s1_q; end
      S_MUL_WS: begin mul_a = t_q;  mul_b = s2_q; end
      S_MUL_D:  begin mul_a = {1'b0, theta_q}; mul_b = DIST_SCALE; end
      default: ;
    endcase
  end

  always_comb begin
    state_d         = state_q;
    in_i.ready      = 1'b0;
    cctrl.start     = 1'b0;
    cctrl.vectoring = 1'b0;
    c_x0            = CORDIC_START_X;
    c_y0            = '0;
    c_z0            = ang;
    commit          = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = have_prev_q ? S_PREP : S_DONE;
        end
      end
      S_PREP:    state_d = S_ANG_MUL;
      S_ANG_MUL: state_d = S_ANG;
      S_ANG: begin
        cctrl.start = 1'b1;
        state_d     = S_ROT;
      end
      S_ROT: begin
        if (c_done) begin
          state_d = (job_q == 2'd3) ? S_MUL_CC : S_PREP;
        end
      end
      S_MUL_CC: state_d = S_RND_P;
      S_RND_P:  state_d = S_MUL_PS;
      S_MUL_PS: state_d = S_RND_W;
      S_RND_W:  state_d = S_MUL_WS;
      S_MUL_WS: state_d = S_SUM;
      S_SUM:    state_d = (a_clamp == '0) ? S_DONE : S_SQ1;
      S_SQ1:    if (sq_cnt_q == 5'd31) state_d = S_SQ2I;
      S_SQ2I:   state_d = S_SQ2;
      S_SQ2:    if (sq_cnt_q == 5'd31) state_d = S_VGO;
      S_VGO: begin
        cctrl.start     = 1'b1;
        cctrl.vectoring = 1'b1;
        c_x0            = CW'(sqx_q);
        c_y0            = CW'(res_q[30:0]);
        c_z0            = '0;
        state_d         = S_VEC;
      end
      S_VEC:    if (c_done) state_d = S_MUL_D;
      S_MUL_D:  state_d = S_RND_D;
      S_RND_D:  state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      have_prev_q <= 1'b0;
      total_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      last_lat_q  <= '0;
      last_lon_q  <= '0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
        have_prev_q <= 1'b1;
        last_lat_q  <= new_lat_q;
        last_lon_q  <= new_lon_q;
        if (!first_q) begin
          total_q <= total_sum[48] ? '1 : total_sum[47:0];
        end
        if (count_q != '1) begin
          count_q <= count_q + 1'b1;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    if (accept) begin
      new_lat_q <= in_i.latitude;
      new_lon_q <= in_i.longitude;
      first_q   <= !have_prev_q;
      seg_q     <= '0;
      job_q     <= '0;
    end
    if (commit) begin
      out_first_q <= first_q;
      out_seg_q   <= seg_q;
    end
    case (state_q)
      S_PREP: begin
        m_q   <= m_d;
        neg_q <= neg_d;
      end
      S_ROT: begin
        if (c_done) begin
          job_q <= job_q + 2'd1;
          case (job_q)
            2'd0: s1_q <= sin_c;
            2'd1: s2_q <= sin_c;
            2'd2: c1_q <= neg_q ? -cos_c : cos_c;
            default: c2_q <= neg_q ? -cos_c : cos_c;
          endcase
        end
      end
      S_RND_P:  t_q <= round_q30(mul_q);
      S_RND_W:  t_q <= round_q30(mul_q);
      S_MUL_WS: acc_q <= mul_q;
      S_SUM: begin
        a_q      <= a_clamp;
        n_q      <= 64'(ONE_Q60[60:0] - a_clamp);
        res_q    <= '0;
        bit_q    <= 64'h4000_0000_0000_0000;
        sq_cnt_q <= '0;
      end
      S_SQ1, S_SQ2: begin
        // One result bit per cycle of the digit-by-digit square root.
        if (n_q >= trial) begin
          n_q   <= n_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q    <= bit_q >> 2;
        sq_cnt_q <= sq_cnt_q + 5'd1;
      end
      S_SQ2I: begin
        sqx_q    <= res_q[30:0];
        n_q      <= 64'(a_q);
        res_q    <= '0;
        bit_q    <= 64'h4000_0000_0000_0000;
        sq_cnt_q <= '0;
      end
      S_VEC:   if (c_done) theta_q <= theta_c[30:0];
      S_RND_D: seg_q <= rnd[57:30];
      default: ;
    endcase
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.first_fix        = out_first_q;
  assign out_o.segment_distance = out_seg_q;
  assign out_o.total_distance   = total_q;
  assign out_o.fix_count        = count_q;
endmodule
`default_nettype wire

// File: tb/haversine_track_distance_unit_tb.sv
// Testbench for the haversine track distance unit: directed fixes, random tracks, scoreboard.
`default_nettype none
module haversine_track_distance_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import htd_pkg::*;

  localparam int ITER = 24;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam longint unsigned PI_Q60_U = 64'h3243F6A8885A308D;
  localparam longint unsigned RAD_PER_UNIT = (PI_Q60_U + 64'd900000000) / 64'd1800000000;
  localparam longint ONE30 = 64'sd1 << 30;
  localparam longint ONE60 = 64'sd1 << 60;
  localparam longint TOTAL_SAT = (64'sd1 << 48) - 1;
  localparam longint COUNT_SAT = 64'hFFFFFFFF;
  localparam longint ARCTAN [0:ITER-1] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFD, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  typedef struct {
    logic        first_fix;
    logic [27:0] segment_distance;
    logic [47:0] total_distance;
    logic [31:0] fix_count;
  } leg_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  htd_in_if  in_bus ();
  htd_out_if out_bus ();

  haversine_track_distance_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  leg_result_t pending_legs[$];
  longint prev_lat, prev_lon;
  longint unsigned track_total, fixes_taken;
  bit has_prev;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int mismatches = 0, legs_checked = 0, fixes_sent = 0, cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_bus.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void rotate(input longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = CORDIC_START_X;
    y = 0;
    z = ang;
    for (int i = 0; i < ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    s = (y > ONE30) ? ONE30 : (y < -ONE30) ? -ONE30 : y;
    c = (x > ONE30) ? ONE30 : (x < -ONE30) ? -ONE30 : x;
  endfunction

  function automatic longint arc_angle(input longint x0, input longint y0);
    longint x, y, z, dx, dy;
    x = x0;
    y = y0;
    z = 0;
    for (int i = 0; i < ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ARCTAN[i];
      end else begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end
    end
    if (z < 0) z = 0;
    if (z > HALF_PI_Q30) z = HALF_PI_Q30;
    return z;
  endfunction

  function automatic longint int_sqrt(input longint unsigned n);
    longint unsigned acc, b;
    acc = 0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= acc + b) begin
        n -= acc + b;
        acc = (acc >> 1) + b;
      end else begin
        acc >>= 1;
      end
      b >>= 2;
    end
    return longint'(acc);
  endfunction

  function automatic longint half_angle_sin(input longint d);
    longint r, s, c;
    longint unsigned m;
    r = d % 64'sd3600000000;
    if (r < 0) r += 64'sd3600000000;
    if (r >= 64'sd1800000000) r -= 64'sd3600000000;
    m = (r < 0) ? -r : r;
    rotate(longint'((m * RAD_PER_UNIT + (64'd1 << 30)) >> 31), s, c);
    return s;
  endfunction

  function automatic longint latitude_cos(input longint lat);
    longint unsigned m;
    longint s, c;
    bit flip;
    m = (lat < 0) ? -lat : lat;
    flip = 0;
    if (m > 64'd900000000) begin
      m = 64'd1800000000 - m;
      flip = 1;
    end
    rotate(longint'((m * RAD_PER_UNIT + (64'd1 << 29)) >> 30), s, c);
    return flip ? -c : c;
  endfunction

  function automatic longint q30_round(input longint v);
    return (v + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic longint great_circle_dm(input longint lat1, input longint lon1,
                                            input longint lat2, input longint lon2);
    longint s1, s2, p30, w30, a, theta;
    s1 = half_angle_sin(lat2 - lat1);
    s2 = half_angle_sin(lon2 - lon1);
    p30 = q30_round(latitude_cos(lat1) * latitude_cos(lat2));
    w30 = q30_round(p30 * s2);
    a = s1 * s1 + w30 * s2;
    if (a < 0) a = 0;
    if (a > ONE60) a = ONE60;
    if (a == 0) return 0;
    theta = arc_angle(int_sqrt(ONE60 - a), int_sqrt(a));
    return ((64'sd127420000 * theta + (64'sd1 << 29)) >> 30) & 64'hFFFFFFF;
  endfunction

  function automatic void predict_fix(input longint lat, input longint lon);
    leg_result_t r;
    longint seg;
    seg = 0;
    r.first_fix = !has_prev;
    if (has_prev) begin
      seg = great_circle_dm(prev_lat, prev_lon, lat, lon);
      track_total += seg;
      if (track_total > TOTAL_SAT) track_total = TOTAL_SAT;
    end
    prev_lat = lat;
    prev_lon = lon;
    if (fixes_taken < COUNT_SAT) fixes_taken++;
    has_prev = 1;
    r.segment_distance = seg[27:0];
    r.total_distance = track_total[47:0];
    r.fix_count = fixes_taken[31:0];
    pending_legs = {pending_legs, r};
  endfunction

  task automatic note_mismatch(input string field, input longint expv, input longint actv);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", field, expv, actv);
    end
  endtask

  always @(posedge clk_i) begin
    leg_result_t e;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_legs.size() == 0) begin
        note_mismatch("unexpected beat", 0, 1);
      end else begin
        e = pending_legs.pop_front();
        legs_checked++;
        if (out_bus.first_fix !== e.first_fix)
          note_mismatch("first_fix", longint'(e.first_fix), longint'(out_bus.first_fix));
        if (out_bus.segment_distance !== e.segment_distance)
          note_mismatch("segment_distance", longint'(e.segment_distance),
                        longint'(out_bus.segment_distance));
        if (out_bus.total_distance !== e.total_distance)
          note_mismatch("total_distance", longint'(e.total_distance),
                        longint'(out_bus.total_distance));
        if (out_bus.fix_count !== e.fix_count)
          note_mismatch("fix_count", longint'(e.fix_count), longint'(out_bus.fix_count));
      end
    end
  end

  // Drives one fix from a falling edge and holds it until the beat is taken.
  task automatic send_fix(input logic signed [30:0] lat, input logic signed [31:0] lon);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_bus.valid = 1'b1;
    in_bus.latitude = lat;
    in_bus.longitude = lon;
    do @(posedge clk_i); while (!in_bus.ready);
    predict_fix(longint'(lat), longint'(lon));
    fixes_sent++;
    @(negedge clk_i);
    in_bus.valid = 1'b0;
  endtask

  task automatic test_first_fix();
    send_fix(31'sd473977000, 32'sd85449000);
    send_fix(31'sd473977000, 32'sd85449000);
    send_fix(31'sd473978000, 32'sd85451000);
  endtask

  task automatic test_special_points();
    send_fix(31'sd0, 32'sd0);
    send_fix(31'sd0, 32'sd1800000000);
    send_fix(31'sd900000000, 32'sd0);
    send_fix(-31'sd900000000, 32'sd0);
    send_fix(31'sd0, -32'sd1800000000);
    send_fix(31'sd1, 32'sd1799999999);
    send_fix(31'sd0, -32'sd1799999999);
    send_fix(31'sd899999999, 32'sd1200000000);
  endtask

  // Latitudes past the poles and longitude differences beyond a half turn.
  task automatic test_field_extremes();
    send_fix(31'sh3FFFFFFF, 32'sh7FFFFFFF);
    send_fix(31'sh40000000, 32'sh80000000);
    send_fix(31'sh3FFFFFFF, 32'sh80000000);
    send_fix(31'sd1000000000, 32'sh7FFFFFFF);
    send_fix(-31'sd1000000000, 32'sd0);
    send_fix(31'sd0, 32'sh55555555);
    send_fix(31'sh2AAAAAAA, 32'shAAAAAAAA);
    send_fix(31'sd0, 32'sd0);
  endtask

  // Mostly short tracks of small random moves, with full-range jumps mixed in.
  task automatic test_random_tracks(input int n, input int idle_pct, input int stall_pct);
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    int k;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    lat = '0;
    lon = '0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 12) begin
        lat = 31'($urandom);
        lon = 32'($urandom);
      end else if ($urandom_range(99) < 8) begin
        lat = 31'($urandom_range(32'd1800000000) - 32'd900000000);
        lon = 32'($urandom_range(32'd3600000000) - 32'd1800000000);
      end else if ($urandom_range(99) >= 5) begin
        k = $urandom_range(2, 28);
        lat = 31'(lat + ($signed($urandom_range(0, 1 << k)) >>> 2)
                  - (1 << (k - 3 > 0 ? k - 3 : 0)));
        lon = 32'(lon + $signed($urandom_range(0, 1 << k)) - (1 << (k - 1)));
      end
      send_fix(lat, lon);
    end
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.latitude = '0;
    in_bus.longitude = '0;
    prev_lat = 0;
    prev_lon = 0;
    track_total = 0;
    fixes_taken = 0;
    has_prev = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_first_fix();
    test_special_points();
    test_field_extremes();
    test_random_tracks(190, 33, 69);
    test_random_tracks(190, 69, 33);
    test_random_tracks(190, 0, 0);
    while (pending_legs.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d fixes (directed and random tracks), checked %0d results.",
             fixes_sent, legs_checked);
    $display("Mismatches found: %0d.", mismatches);
    if (mismatches == 0 && pending_legs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
